[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, switched off while reset is high
`define BW_ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define BW_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BW_ASSERT_CLK(name, clk, rst, prop, msg)
`define BW_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

[rtl/bw_pkg.sv]
// ----------------------------------------------------------------------------
// bw_pkg
// shared constants of the barycentric weight pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package bw_pkg;
  localparam int COORD_BITS_DEF       = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;
  // sign plus three integer bits of a Q3.F weight
  localparam int WEIGHT_INT_BITS      = 4;
  localparam int AXES                 = 3;
  localparam int LANES                = 3;
  // lane order of the weights
  localparam int LANE_U               = 0;
  localparam int LANE_V               = 1;
  localparam int LANE_W               = 2;
endpackage

`default_nettype wire

[rtl/bw_query_if.sv]
// ----------------------------------------------------------------------------
// bw_query_if
// query channel: point and three triangle vertices, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bw_query_if #(
  parameter int COORD_BITS = bw_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic signed [COORD_BITS-1:0] vert_a_x;
  logic signed [COORD_BITS-1:0] vert_a_y;
  logic signed [COORD_BITS-1:0] vert_a_z;
  logic signed [COORD_BITS-1:0] vert_b_x;
  logic signed [COORD_BITS-1:0] vert_b_y;
  logic signed [COORD_BITS-1:0] vert_b_z;
  logic signed [COORD_BITS-1:0] vert_c_x;
  logic signed [COORD_BITS-1:0] vert_c_y;
  logic signed [COORD_BITS-1:0] vert_c_z;

  modport source (
    output valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z,
           vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

`default_nettype wire

[rtl/bw_result_if.sv]
// ----------------------------------------------------------------------------
// bw_result_if
// result channel: three weights and two flags, valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bw_result_if #(
  parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS_DEF
) ();
  localparam int WB = WEIGHT_FRAC_BITS + bw_pkg::WEIGHT_INT_BITS;

  logic                 valid;
  logic                 ready;
  logic signed [WB-1:0] weight_u;
  logic signed [WB-1:0] weight_v;
  logic signed [WB-1:0] weight_w;
  logic                 degenerate;
  logic                 saturated;

  modport source (
    output valid, weight_u, weight_v, weight_w, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, weight_u, weight_v, weight_w, degenerate, saturated,
    output ready
  );
endinterface

`default_nettype wire

[rtl/bw_dot.sv]
// ----------------------------------------------------------------------------
// bw_dot
// edge vectors and the five dot products, two register stages
// ----------------------------------------------------------------------------
`default_nettype none

module bw_dot #(
  parameter int COORD_BITS = bw_pkg::COORD_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire logic signed [COORD_BITS-1:0] pt [bw_pkg::AXES],
  input  wire logic signed [COORD_BITS-1:0] va [bw_pkg::AXES],
  input  wire logic signed [COORD_BITS-1:0] vb [bw_pkg::AXES],
  input  wire logic signed [COORD_BITS-1:0] vc [bw_pkg::AXES],
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [2*COORD_BITS+3:0]   d00,
  output logic signed [2*COORD_BITS+3:0]   d01,
  output logic signed [2*COORD_BITS+3:0]   d11,
  output logic signed [2*COORD_BITS+3:0]   d20,
  output logic signed [2*COORD_BITS+3:0]   d21
);
  localparam int EW = COORD_BITS + 1;
  localparam int PW = 2 * EW;
  localparam int DW = 2 * COORD_BITS + 4;

  logic v1;
  logic v2;
  logic en1;
  logic en2;

  logic signed [EW-1:0] e0 [bw_pkg::AXES];
  logic signed [EW-1:0] e1 [bw_pkg::AXES];
  logic signed [EW-1:0] e2 [bw_pkg::AXES];

  logic signed [PW-1:0] p00 [bw_pkg::AXES];
  logic signed [PW-1:0] p01 [bw_pkg::AXES];
  logic signed [PW-1:0] p11 [bw_pkg::AXES];
  logic signed [PW-1:0] p20 [bw_pkg::AXES];
  logic signed [PW-1:0] p21 [bw_pkg::AXES];

  assign en2       = !v2 || out_ready;
  assign en1       = !v1 || en2;
  assign in_ready  = en1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_comb begin
    for (int k = 0; k < bw_pkg::AXES; k++) begin
      p00[k] = e0[k] * e0[k];
      p01[k] = e0[k] * e1[k];
      p11[k] = e1[k] * e1[k];
      p20[k] = e2[k] * e0[k];
      p21[k] = e2[k] * e1[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int k = 0; k < bw_pkg::AXES; k++) begin
        e0[k] <= EW'(vb[k]) - EW'(va[k]);
        e1[k] <= EW'(vc[k]) - EW'(va[k]);
        e2[k] <= EW'(pt[k]) - EW'(va[k]);
      end
    end
    if (en2) begin
      d00 <= DW'(p00[0]) + DW'(p00[1]) + DW'(p00[2]);
      d01 <= DW'(p01[0]) + DW'(p01[1]) + DW'(p01[2]);
      d11 <= DW'(p11[0]) + DW'(p11[1]) + DW'(p11[2]);
      d20 <= DW'(p20[0]) + DW'(p20[1]) + DW'(p20[2]);
      d21 <= DW'(p21[0]) + DW'(p21[1]) + DW'(p21[2]);
    end
  end
endmodule

`default_nettype wire

[rtl/bw_cross.sv]
// ----------------------------------------------------------------------------
// bw_cross
// six wide products from half-width partials, then denominator and
// numerators; three register stages
// ----------------------------------------------------------------------------
`default_nettype none

module bw_cross #(
  parameter int COORD_BITS = bw_pkg::COORD_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire logic signed [2*COORD_BITS+3:0] d00,
  input  wire logic signed [2*COORD_BITS+3:0] d01,
  input  wire logic signed [2*COORD_BITS+3:0] d11,
  input  wire logic signed [2*COORD_BITS+3:0] d20,
  input  wire logic signed [2*COORD_BITS+3:0] d21,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [4*COORD_BITS+7:0]           den,
  output logic signed [4*COORD_BITS+10:0]   num [bw_pkg::LANES],
  output logic                              degenerate
);
  localparam int DW    = 2 * COORD_BITS + 4;
  localparam int LO    = DW / 2;
  localparam int HI    = DW - LO;
  localparam int PPW   = DW + 2;
  localparam int MW    = 2 * DW;
  localparam int NW    = MW + 3;
  localparam int NPROD = 6;
  // product order: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
  localparam int P_00_11 = 0;
  localparam int P_01_01 = 1;
  localparam int P_11_20 = 2;
  localparam int P_01_21 = 3;
  localparam int P_00_21 = 4;
  localparam int P_01_20 = 5;

  logic v3;
  logic v4;
  logic v5;
  logic en3;
  logic en4;
  logic en5;

  logic signed [DW-1:0]  opa [NPROD];
  logic signed [DW-1:0]  opb [NPROD];
  logic signed [HI-1:0]  ah  [NPROD];
  logic signed [HI-1:0]  bh  [NPROD];
  logic signed [LO:0]    al  [NPROD];
  logic signed [LO:0]    bl  [NPROD];
  logic signed [PPW-1:0] pp_hh [NPROD];
  logic signed [PPW-1:0] pp_hl [NPROD];
  logic signed [PPW-1:0] pp_lh [NPROD];
  logic signed [PPW-1:0] pp_ll [NPROD];
  logic signed [MW-1:0]  prod  [NPROD];

  assign en5       = !v5 || out_ready;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign in_ready  = en3;
  assign out_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en3) v3 <= in_valid;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  always_comb begin
    opa[P_00_11] = d00;  opb[P_00_11] = d11;
    opa[P_01_01] = d01;  opb[P_01_01] = d01;
    opa[P_11_20] = d11;  opb[P_11_20] = d20;
    opa[P_01_21] = d01;  opb[P_01_21] = d21;
    opa[P_00_21] = d00;  opb[P_00_21] = d21;
    opa[P_01_20] = d01;  opb[P_01_20] = d20;
    for (int i = 0; i < NPROD; i++) begin
      // signed upper half, unsigned lower half
      ah[i] = opa[i][DW-1:LO];
      bh[i] = opb[i][DW-1:LO];
      al[i] = {1'b0, opa[i][LO-1:0]};
      bl[i] = {1'b0, opb[i][LO-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < NPROD; i++) begin
        pp_hh[i] <= ah[i] * bh[i];
        pp_hl[i] <= ah[i] * bl[i];
        pp_lh[i] <= al[i] * bh[i];
        pp_ll[i] <= al[i] * bl[i];
      end
    end
    if (en4) begin
      for (int i = 0; i < NPROD; i++) begin
        prod[i] <= (MW'(pp_hh[i]) <<< (2 * LO))
                 + ((MW'(pp_hl[i]) + MW'(pp_lh[i])) <<< LO)
                 + MW'(pp_ll[i]);
      end
    end
    if (en5) begin
      den        <= prod[P_00_11] - prod[P_01_01];
      degenerate <= (prod[P_00_11] == prod[P_01_01]);
      num[bw_pkg::LANE_V] <= NW'(prod[P_11_20]) - NW'(prod[P_01_21]);
      num[bw_pkg::LANE_W] <= NW'(prod[P_00_21]) - NW'(prod[P_01_20]);
      // u numerator straight from the products: den - nv - nw
      num[bw_pkg::LANE_U] <= NW'(prod[P_00_11]) - NW'(prod[P_01_01])
                           - NW'(prod[P_11_20]) + NW'(prod[P_01_21])
                           - NW'(prod[P_00_21]) + NW'(prod[P_01_20]);
    end
  end
endmodule

`default_nettype wire

[rtl/bw_divider.sv]
// ----------------------------------------------------------------------------
// bw_divider
// three-lane pipelined restoring divider: magnitude, range check, one
// quotient bit per stage, then rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module bw_divider #(
  parameter int COORD_BITS       = bw_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire logic [4*COORD_BITS+7:0]       den,
  input  wire logic signed [4*COORD_BITS+10:0] num [bw_pkg::LANES],
  input  wire                                degenerate,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [WEIGHT_FRAC_BITS+bw_pkg::WEIGHT_INT_BITS-1:0]
                                             weight [bw_pkg::LANES],
  output logic                               out_degenerate,
  output logic                               saturated
);
  localparam int IB   = bw_pkg::WEIGHT_INT_BITS;
  localparam int LN   = bw_pkg::LANES;
  localparam int MW   = 4 * COORD_BITS + 8;
  localparam int NW   = MW + 3;
  localparam int WB   = WEIGHT_FRAC_BITS + IB;
  localparam int QB   = WB + 1;
  localparam int RW   = MW + IB + 1;
  localparam int RW1  = RW + 1;
  localparam int QB1  = QB + 1;
  localparam int NST  = QB + 3;
  localparam int ST_ABS   = 0;
  localparam int ST_RANGE = 1;
  localparam int ST_STEP0 = 2;
  localparam int ST_ROUND = NST - 1;
  localparam logic [QB-1:0] LIM_POS = {2'b00, {(WB-1){1'b1}}};
  localparam logic [QB-1:0] LIM_NEG = {2'b01, {(WB-1){1'b0}}};

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // magnitude stage
  logic signed [RW-1:0] num_ext [LN];
  logic [RW-1:0] a_mag [LN];
  logic          a_sign [LN];
  logic [MW-1:0] a_den;
  logic          a_degen;

  // range check stage
  logic [RW-1:0] r_mag [LN];
  logic          r_sign [LN];
  logic          r_ovf [LN];
  logic [MW-1:0] r_den;
  logic          r_degen;

  // quotient bit stages
  logic [RW-1:0] s_rem  [QB][LN];
  logic [QB-1:0] s_q    [QB][LN];
  logic          s_sign [QB][LN];
  logic          s_ovf  [QB][LN];
  logic [MW-1:0] s_den  [QB];
  logic          s_degen [QB];

  // rounding
  logic [QB:0]   qinc [LN];
  logic [QB-1:0] qr   [LN];
  logic [QB-1:0] lim  [LN];
  logic          over [LN];
  logic [QB-1:0] sel  [LN];
  logic [WB-1:0] selw [LN];

  for (genvar k = 0; k < NST; k++) begin : g_en
    if (k == NST - 1) begin : g_last
      assign en[k] = !v[k] || out_ready;
    end else begin : g_mid
      assign en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[ST_ABS];
  assign out_valid = v[ST_ROUND];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      num_ext[l] = RW'(num[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      for (int l = 0; l < LN; l++) begin
        a_sign[l] <= num[l][NW-1];
        a_mag[l]  <= num[l][NW-1] ? -num_ext[l] : num_ext[l];
      end
      a_den   <= den;
      a_degen <= degenerate;
    end
    if (en[ST_RANGE]) begin
      for (int l = 0; l < LN; l++) begin
        r_mag[l]  <= a_mag[l];
        r_sign[l] <= a_sign[l];
        // quotient of 2**IB or more, beyond the integer bits that the quotient steps produce
        r_ovf[l]  <= a_mag[l] >= (RW'(a_den) << IB);
      end
      r_den   <= a_den;
      r_degen <= a_degen;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int SH  = (j < IB) ? (IB - 1 - j) : 0;
    localparam bit DBL = (j >= IB);

    logic [RW-1:0]  rem_in  [LN];
    logic [QB-1:0]  q_in    [LN];
    logic           sign_in [LN];
    logic           ovf_in  [LN];
    logic [MW-1:0]  den_in;
    logic           degen_in;
    logic [RW-1:0]  cand [LN];
    logic [RW1-1:0] diff [LN];

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LN; l++) begin
          rem_in[l]  = r_mag[l];
          q_in[l]    = '0;
          sign_in[l] = r_sign[l];
          ovf_in[l]  = r_ovf[l];
        end
        den_in   = r_den;
        degen_in = r_degen;
      end
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < LN; l++) begin
          rem_in[l]  = s_rem[j-1][l];
          q_in[l]    = s_q[j-1][l];
          sign_in[l] = s_sign[j-1][l];
          ovf_in[l]  = s_ovf[j-1][l];
        end
        den_in   = s_den[j-1];
        degen_in = s_degen[j-1];
      end
    end

    always_comb begin
      for (int l = 0; l < LN; l++) begin
        cand[l] = DBL ? {rem_in[l][RW-2:0], 1'b0} : rem_in[l];
        diff[l] = {1'b0, cand[l]} - (RW1'(den_in) << SH);
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_STEP0+j]) begin
        for (int l = 0; l < LN; l++) begin
          s_rem[j][l]  <= diff[l][RW] ? cand[l] : diff[l][RW-1:0];
          s_q[j][l]    <= {q_in[l][QB-2:0], !diff[l][RW]};
          s_sign[j][l] <= sign_in[l];
          s_ovf[j][l]  <= ovf_in[l];
        end
        s_den[j]   <= den_in;
        s_degen[j] <= degen_in;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      // half-up on the magnitude: ties go away from zero
      qinc[l] = {1'b0, s_q[QB-1][l]} + QB1'(1);
      qr[l]   = qinc[l][QB:1];
      lim[l]  = s_sign[QB-1][l] ? LIM_NEG : LIM_POS;
      over[l] = s_ovf[QB-1][l] || (qr[l] > lim[l]);
      sel[l]  = over[l] ? lim[l] : qr[l];
      selw[l] = sel[l][WB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_ROUND]) begin
      for (int l = 0; l < LN; l++) begin
        if (s_degen[QB-1]) begin
          weight[l] <= '0;
        end else begin
          weight[l] <= s_sign[QB-1][l] ? (~selw[l] + WB'(1)) : selw[l];
        end
      end
      out_degenerate <= s_degen[QB-1];
      saturated      <= !s_degen[QB-1] && (over[0] || over[1] || over[2]);
    end
  end
endmodule

`default_nettype wire

[rtl/barycentric_weights.sv]
// throughput: one item per cycle while result.ready is high; the divider is pipelined, one quotient bit per stage
// stalls: each stage fills its own bubble, so items keep entering while a result waits
// reset: synchronous, active high; clears every stage valid bit, payload is not reset
// ----------------------------------------------------------------------------
// barycentric_weights
// barycentric weights u, v, w of a point against a 3-d triangle, Q3.F with
// saturation and a degenerate-triangle flag
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module barycentric_weights #(
  parameter int COORD_BITS       = bw_pkg::COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input wire           clk,
  input wire           rst,
  bw_query_if.sink     query,
  bw_result_if.source  result
);
  localparam int DW = 2 * COORD_BITS + 4;      // dot product width
  localparam int MW = 2 * DW;                  // denominator width
  localparam int NW = MW + 3;                  // numerator width
  localparam int WB = WEIGHT_FRAC_BITS + bw_pkg::WEIGHT_INT_BITS;
  localparam int SW = WB + 2;                  // weight sum width
  localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
  localparam logic signed [SW-1:0] W_ONE = SW'(1) << WEIGHT_FRAC_BITS;

  // query coordinates regrouped per axis
  logic signed [COORD_BITS-1:0] pt [bw_pkg::AXES];
  logic signed [COORD_BITS-1:0] va [bw_pkg::AXES];
  logic signed [COORD_BITS-1:0] vb [bw_pkg::AXES];
  logic signed [COORD_BITS-1:0] vc [bw_pkg::AXES];

  // dot products, edges e0 = b - a, e1 = c - a, e2 = p - a
  logic                 dot_valid;
  logic                 dot_ready;
  logic signed [DW-1:0] d00;
  logic signed [DW-1:0] d01;
  logic signed [DW-1:0] d11;
  logic signed [DW-1:0] d20;
  logic signed [DW-1:0] d21;

  // exact denominator and numerators of u, v, w
  logic                 crs_valid;
  logic                 crs_ready;
  logic [MW-1:0]        den;
  logic signed [NW-1:0] num [bw_pkg::LANES];
  logic                 crs_degen;

  // rounded, saturated weights
  logic signed [WB-1:0] weight [bw_pkg::LANES];
  logic signed [SW-1:0] wsum_err;

  always_comb begin
    pt[0] = query.point_x;   pt[1] = query.point_y;   pt[2] = query.point_z;
    va[0] = query.vert_a_x;  va[1] = query.vert_a_y;  va[2] = query.vert_a_z;
    vb[0] = query.vert_b_x;  vb[1] = query.vert_b_y;  vb[2] = query.vert_b_z;
    vc[0] = query.vert_c_x;  vc[1] = query.vert_c_y;  vc[2] = query.vert_c_z;
  end

  // stages 1-2: edge vectors, then dot products
  bw_dot #(
    .COORD_BITS (COORD_BITS)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (query.valid),
    .in_ready  (query.ready),
    .pt        (pt),
    .va        (va),
    .vb        (vb),
    .vc        (vc),
    .out_valid (dot_valid),
    .out_ready (dot_ready),
    .d00       (d00),
    .d01       (d01),
    .d11       (d11),
    .d20       (d20),
    .d21       (d21)
  );

  // stages 3-5: partial products, full products, den and numerators
  bw_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dot_valid),
    .in_ready   (dot_ready),
    .d00        (d00),
    .d01        (d01),
    .d11        (d11),
    .d20        (d20),
    .d21        (d21),
    .out_valid  (crs_valid),
    .out_ready  (crs_ready),
    .den        (den),
    .num        (num),
    .degenerate (crs_degen)
  );

  // remaining stages: magnitude, range check, one quotient bit per stage,
  // round and saturate into the output register
  bw_divider #(
    .COORD_BITS       (COORD_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_divider (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (crs_valid),
    .in_ready       (crs_ready),
    .den            (den),
    .num            (num),
    .degenerate     (crs_degen),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .weight         (weight),
    .out_degenerate (result.degenerate),
    .saturated      (result.saturated)
  );

  assign result.weight_u = weight[bw_pkg::LANE_U];
  assign result.weight_v = weight[bw_pkg::LANE_V];
  assign result.weight_w = weight[bw_pkg::LANE_W];

  // each weight is rounded once, so the three sum to one within one lsb
  assign wsum_err = SW'(result.weight_u) + SW'(result.weight_v)
                  + SW'(result.weight_w) - W_ONE;

  `BW_ASSERT_CLK(a_degen_zero, clk, rst, result.valid && result.degenerate |-> (result.weight_u == '0) && (result.weight_v == '0) && (result.weight_w == '0) && !result.saturated, "degenerate item with nonzero weights or saturation")
  `BW_ASSERT_CLK(a_sum_one, clk, rst, result.valid && !result.degenerate && !result.saturated |-> (wsum_err == '0) || (wsum_err == SW'(1)) || (wsum_err == -SW'(1)), "weights do not sum to one")
  `BW_ASSERT_CLK(a_sat_limit, clk, rst, result.valid && result.saturated |-> (result.weight_u == W_MAX) || (result.weight_u == W_MIN) || (result.weight_v == W_MAX) || (result.weight_v == W_MIN) || (result.weight_w == W_MAX) || (result.weight_w == W_MIN), "saturated item with no weight at a limit")
  `BW_ASSERT_CLK(a_full_stall, clk, rst, !query.ready |-> result.valid && !result.ready, "query refused while the pipeline can still move")
endmodule

`default_nettype wire
